@@ src/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the touch slide reversal detector
// Holds the field widths, reset values, register indexes and the reverse code.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

	localparam int MAX_TOUCH_IDS_DEF = 16;
	localparam int WINDOW_DEPTH_DEF  = 6;
	localparam int COORD_WIDTH_DEF   = 20;

	localparam int TS_WIDTH   = 63;
	localparam int ID_WIDTH   = 4;
	localparam int GAP_WIDTH  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAP_WIDTH;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_GAP = CFG_IDX_W'(1);

	localparam logic                 ENABLE_RESET    = 1'b1;
	localparam logic [GAP_WIDTH-1:0] CLEAR_GAP_RESET = GAP_WIDTH'(30 * 1000 * 1000);

	typedef enum logic [1:0] {
		CODE_NONE      = 2'd0,
		CODE_INITIAL   = 2'd1,
		CODE_DOWN_LEFT = 2'd2,
		CODE_UP_RIGHT  = 2'd3
	} rev_code_t;

endpackage

`default_nettype wire

@@ src/tsr_ifs.sv @@
// ----------------------------------------------------------------------------
// tsr_ifs: channel interfaces of the touch slide reversal detector
// Touch event channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsr_evt_if #(
	parameter int COORD_WIDTH = tsr_pkg::COORD_WIDTH_DEF
);
	logic                            valid;
	logic                            ready;
	logic                            first_in_batch;
	logic [tsr_pkg::TS_WIDTH-1:0]    timestamp_ns;
	logic [tsr_pkg::ID_WIDTH-1:0]    touch_id;
	logic                            is_finger;
	logic                            is_move;
	logic signed [COORD_WIDTH-1:0]   x_pos;
	logic signed [COORD_WIDTH-1:0]   y_pos;
	logic [1:0]                      x_reverse_in;
	logic [1:0]                      y_reverse_in;

	modport source (
		output valid, first_in_batch, timestamp_ns, touch_id, is_finger, is_move,
		output x_pos, y_pos, x_reverse_in, y_reverse_in,
		input  ready
	);
	modport sink (
		input  valid, first_in_batch, timestamp_ns, touch_id, is_finger, is_move,
		input  x_pos, y_pos, x_reverse_in, y_reverse_in,
		output ready
	);
endinterface

interface tsr_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] x_reverse_out;
	logic [1:0] y_reverse_out;
	logic       not_processed;

	modport source (
		output valid, x_reverse_out, y_reverse_out, not_processed,
		input  ready
	);
	modport sink (
		input  valid, x_reverse_out, y_reverse_out, not_processed,
		output ready
	);
endinterface

`default_nettype wire

@@ src/touch_slide_reversal_detector.sv @@
// ----------------------------------------------------------------------------
// touch_slide_reversal_detector: per-id slide reversal detection on touch events
// A taken event transaction is registered in stage 1; its result is offered from the output register.
// Throughput: one event per cycle while res.ready does not stall; the window RAM read/write loop is forwarded.
// The window RAM read is launched with the transaction; the update follows.
// Reset clears fill counts, batch time and abort flag; enable = 1, gap = 30 ms.
// Window RAM contents have no reset; entries at or above the fill are unused.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_slide_reversal_detector #(
	parameter int MAX_TOUCH_IDS = tsr_pkg::MAX_TOUCH_IDS_DEF,
	parameter int WINDOW_DEPTH  = tsr_pkg::WINDOW_DEPTH_DEF,
	parameter int COORD_WIDTH   = tsr_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [tsr_pkg::CFG_IDX_W-1:0]    wr_idx,
	input  wire logic [tsr_pkg::CFG_DATA_W-1:0]   wr_data,
	tsr_evt_if.sink                               evt,
	tsr_res_if.source                             res
);
	import tsr_pkg::*;

	localparam int IDX_W   = (MAX_TOUCH_IDS > 1) ? $clog2(MAX_TOUCH_IDS) : 1;
	localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int ROW_W   = WINDOW_DEPTH * COORD_WIDTH;
	localparam int ID_SPAN = 2 ** ID_WIDTH;

	logic [IDX_W-1:0] id_map [ID_SPAN];

	for (genvar g = 0; g < ID_SPAN; g++) begin : g_id_map
		assign id_map[g] = IDX_W'(g % MAX_TOUCH_IDS);
	end

	logic                 enable_q;
	logic [GAP_WIDTH-1:0] gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RESET;
			gap_q    <= CLEAR_GAP_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_ENABLE:    enable_q <= wr_data[0];
				REG_CLEAR_GAP: gap_q    <= wr_data[GAP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	logic                          valid_s1;
	logic                          first_s1;
	logic [TS_WIDTH-1:0]           ts_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          finger_s1;
	logic                          move_s1;
	logic signed [COORD_WIDTH-1:0] x_s1;
	logic signed [COORD_WIDTH-1:0] y_s1;
	rev_code_t                     xc_s1;
	rev_code_t                     yc_s1;

	logic res_valid_q;
	logic advance;
	logic accept;
	logic fire;

	assign advance   = !res_valid_q || res.ready;
	assign evt.ready = !valid_s1 || advance;
	assign accept    = evt.valid && evt.ready;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1  <= evt.first_in_batch;
			ts_s1     <= evt.timestamp_ns;
			idx_s1    <= id_map[evt.touch_id];
			finger_s1 <= evt.is_finger;
			move_s1   <= evt.is_move;
			x_s1      <= evt.x_pos;
			y_s1      <= evt.y_pos;
			xc_s1     <= rev_code_t'(evt.x_reverse_in);
			yc_s1     <= rev_code_t'(evt.y_reverse_in);
		end
	end

	logic [2*ROW_W-1:0] ram_rdata;
	logic [2*ROW_W-1:0] row_s1;
	logic [2*ROW_W-1:0] row_n;
	logic               row_we;
	logic               fwd_valid_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	logic [2*ROW_W-1:0] fwd_row_q;

	tsr_ram #(
		.WIDTH (2 * ROW_W),
		.DEPTH (MAX_TOUCH_IDS)
	) u_window_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (idx_s1),
		.wdata (row_n),
		.re    (accept),
		.raddr (id_map[evt.touch_id]),
		.rdata (ram_rdata)
	);

	assign row_s1 = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_row_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (row_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			fwd_idx_q <= idx_s1;
			fwd_row_q <= row_n;
		end
	end

	logic [FILL_W-1:0]   x_fill_q [MAX_TOUCH_IDS];
	logic [FILL_W-1:0]   y_fill_q [MAX_TOUCH_IDS];
	logic [TS_WIDTH-1:0] last_q;
	logic                aborted_q;

	logic [FILL_W-1:0] x_fill_n;
	logic [FILL_W-1:0] y_fill_n;
	rev_code_t         x_code_n;
	rev_code_t         y_code_n;

	tsr_axis #(
		.DEPTH       (WINDOW_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_axis_x (
		.row    (row_s1[ROW_W-1:0]),
		.fill   (x_fill_q[idx_s1]),
		.sample (x_s1),
		.code   (xc_s1),
		.row_n  (row_n[ROW_W-1:0]),
		.fill_n (x_fill_n),
		.code_n (x_code_n)
	);

	tsr_axis #(
		.DEPTH       (WINDOW_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_axis_y (
		.row    (row_s1[2*ROW_W-1:ROW_W]),
		.fill   (y_fill_q[idx_s1]),
		.sample (y_s1),
		.code   (yc_s1),
		.row_n  (row_n[2*ROW_W-1:ROW_W]),
		.fill_n (y_fill_n),
		.code_n (y_code_n)
	);

	logic signed [TS_WIDTH:0] batch_gap;
	logic                     timeout;
	logic                     skip;
	logic                     clear_all;
	logic                     clear_id;
	logic                     upd;
	logic                     aborted_n;
	logic [TS_WIDTH-1:0]      last_n;

	always_comb begin
		batch_gap = $signed({1'b0, ts_s1}) - $signed({1'b0, last_q});
		timeout   = (batch_gap >= $signed({{(TS_WIDTH + 1 - GAP_WIDTH){1'b0}}, gap_q}))
			&& (last_q != '0);
		skip      = 1'b0;
		clear_all = 1'b0;
		clear_id  = 1'b0;
		upd       = 1'b0;
		aborted_n = aborted_q;
		last_n    = last_q;
		if (!enable_q) begin
			skip = 1'b1;
		end else begin
			if (first_s1) begin
				aborted_n = 1'b0;
				if (timeout) begin
					clear_all = 1'b1;
					aborted_n = 1'b1;
					last_n    = '0;
				end else begin
					last_n = ts_s1;
				end
			end
			priority if (aborted_n) begin
				skip = 1'b1;
			end else if (!finger_s1) begin
				clear_all = 1'b1;
				aborted_n = 1'b1;
				last_n    = '0;
				skip      = 1'b1;
			end else if (!move_s1) begin
				clear_id = 1'b1;
			end else begin
				upd = 1'b1;
			end
		end
	end

	assign row_we = fire && upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			aborted_q <= 1'b0;
			for (int i = 0; i < MAX_TOUCH_IDS; i++) begin
				x_fill_q[i] <= '0;
				y_fill_q[i] <= '0;
			end
		end else if (fire) begin
			last_q    <= last_n;
			aborted_q <= aborted_n;
			for (int i = 0; i < MAX_TOUCH_IDS; i++) begin
				if (clear_all || (clear_id && (IDX_W'(i) == idx_s1))) begin
					x_fill_q[i] <= '0;
					y_fill_q[i] <= '0;
				end else if (upd && (IDX_W'(i) == idx_s1)) begin
					x_fill_q[i] <= x_fill_n;
					y_fill_q[i] <= y_fill_n;
				end
			end
		end
	end

	logic [1:0] x_out_q;
	logic [1:0] y_out_q;
	logic       skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			x_out_q <= upd ? x_code_n : xc_s1;
			y_out_q <= upd ? y_code_n : yc_s1;
			skip_q  <= skip;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.x_reverse_out = x_out_q;
	assign res.y_reverse_out = y_out_q;
	assign res.not_processed = skip_q;

	logic fill_any;

	always_comb begin
		fill_any = 1'b0;
		for (int i = 0; i < MAX_TOUCH_IDS; i++) begin
			fill_any = fill_any || (x_fill_q[i] != '0) || (y_fill_q[i] != '0);
		end
	end

	a_disabled_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !enable_q) |=> (res.valid && res.not_processed))
		else $error("disabled transaction not reported as skipped");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && clear_all) |=> !fill_any)
		else $error("windows not empty after a full clear");

	a_timeout_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && enable_q && first_s1 && timeout) |=> (aborted_q && (last_q == '0)))
		else $error("batch timeout did not abort the batch");

	a_skip_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && skip) |-> !row_we)
		else $error("window written for a skipped transaction");

endmodule

`default_nettype wire

@@ src/tsr_ram.sv @@
// ----------------------------------------------------------------------------
// tsr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ram #(
	parameter  int WIDTH  = 8,
	parameter  int DEPTH  = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/tsr_axis.sv @@
// ----------------------------------------------------------------------------
// tsr_axis: window update and reversal check for one axis
// Pushes a distinct sample into the window and, when full, derives the code.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_axis #(
	parameter  int DEPTH       = tsr_pkg::WINDOW_DEPTH_DEF,
	parameter  int COORD_WIDTH = tsr_pkg::COORD_WIDTH_DEF,
	localparam int FILL_W      = $clog2(DEPTH + 1),
	localparam int ROW_W       = DEPTH * COORD_WIDTH
) (
	input  wire logic        [ROW_W-1:0]       row,
	input  wire logic        [FILL_W-1:0]      fill,
	input  wire logic signed [COORD_WIDTH-1:0] sample,
	input  wire tsr_pkg::rev_code_t            code,
	output logic             [ROW_W-1:0]       row_n,
	output logic             [FILL_W-1:0]      fill_n,
	output tsr_pkg::rev_code_t                 code_n
);
	import tsr_pkg::*;

	localparam int POS_W = $clog2(DEPTH);

	logic signed [COORD_WIDTH-1:0] ent   [DEPTH];
	logic signed [COORD_WIDTH-1:0] shift [DEPTH];
	logic        [ROW_W-1:0]       ins_row;
	logic        [ROW_W-1:0]       shift_row;
	logic        [FILL_W-1:0]      last_pos;
	logic signed [COORD_WIDTH-1:0] newest;
	logic                          dup;
	logic                          full;
	logic                          newest_nonneg;
	logic                          all_oppose;
	rev_code_t                     dir;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent[i] = row[i*COORD_WIDTH +: COORD_WIDTH];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			shift[i] = ent[i+1];
		end
		shift[DEPTH-1] = sample;

		last_pos = fill - FILL_W'(1);
		newest   = ent[last_pos[POS_W-1:0]];
		dup      = (fill != '0) && (newest == sample);
		full     = (fill >= FILL_W'(DEPTH));

		for (int i = 0; i < DEPTH; i++) begin
			ins_row[i*COORD_WIDTH +: COORD_WIDTH]   = (FILL_W'(i) == fill) ? sample : ent[i];
			shift_row[i*COORD_WIDTH +: COORD_WIDTH] = shift[i];
		end

		newest_nonneg = (shift[DEPTH-2] >= shift[DEPTH-1]);
		all_oppose    = 1'b1;
		for (int i = 0; i < DEPTH - 2; i++) begin
			if ((shift[i] >= shift[i+1]) == newest_nonneg) begin
				all_oppose = 1'b0;
			end
		end
		dir = (shift[0] < shift[1]) ? CODE_DOWN_LEFT : CODE_UP_RIGHT;

		priority if (dup) begin
			row_n  = row;
			fill_n = fill;
			code_n = code;
		end else if (!full) begin
			row_n  = ins_row;
			fill_n = fill + FILL_W'(1);
			code_n = code;
		end else begin
			row_n  = shift_row;
			fill_n = fill;
			code_n = ((code != CODE_NONE) || all_oppose) ? dir : code;
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_touch_slide_reversal_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_slide_reversal_detector: self-checking bench for the reversal detector
// A short table of directed events and register writes is followed by random
// touch strokes under several idle patterns and register settings. Every
// accepted event is run through a behavioral copy of the per-id windows and
// the result stream is compared in order, field by field.
// ----------------------------------------------------------------------------

module tb_touch_slide_reversal_detector;

	import tsr_pkg::*;

	localparam int N_IDS        = MAX_TOUCH_IDS_DEF;
	localparam int WIN_DEPTH    = WINDOW_DEPTH_DEF;
	localparam int CW           = COORD_WIDTH_DEF;
	localparam int REPORT_LIMIT = 30;
	localparam int EXP_DEPTH    = 64;
	localparam int ROW_MAX      = 48;

	typedef struct packed {
		logic                first;
		logic [TS_WIDTH-1:0] ts;
		logic [ID_WIDTH-1:0] id;
		logic                finger;
		logic                move;
		logic [CW-1:0]       x;
		logic [CW-1:0]       y;
		rev_code_t           xc;
		rev_code_t           yc;
	} touch_evt_t;

	typedef struct packed {
		rev_code_t x;
		rev_code_t y;
		logic      np;
	} reverse_res_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		touch_evt_t            ev;
		logic                  pinned;
		reverse_res_t          want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_idx;
	logic [CFG_DATA_W-1:0] wr_data;

	tsr_evt_if evt ();
	tsr_res_if res ();

	touch_slide_reversal_detector uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.evt     (evt),
		.res     (res)
	);

	logic signed [CW-1:0] pos_win [2][N_IDS][WIN_DEPTH];
	int                   pos_fill [2][N_IDS];
	logic [TS_WIDTH-1:0]  last_batch_ns;
	logic                 batch_dropped;
	logic                 det_enable;
	logic [GAP_WIDTH-1:0] clear_gap;

	reverse_res_t         exp_store [EXP_DEPTH];
	int                   exp_wr;
	int                   exp_rd;
	stim_row_t            dir_rows [ROW_MAX];
	int                   n_rows;
	int                   mismatch_count;
	logic                 pin_valid;
	reverse_res_t         pin_res;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	logic [TS_WIDTH-1:0]  ts_now;
	logic [GAP_WIDTH-1:0] gap_setting;
	int                   phase_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void flush_windows();
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < N_IDS; i++) begin
				pos_fill[a][i] = 0;
			end
		end
		last_batch_ns = '0;
	endfunction

	function automatic rev_code_t slide_axis(int ax, int id, logic signed [CW-1:0] v,
			rev_code_t code);
		int n;
		longint gap1;
		longint g;
		n = pos_fill[ax][id];
		if (n > 0 && pos_win[ax][id][n-1] == v)
			return code;
		if (n < WIN_DEPTH) begin
			pos_win[ax][id][n] = v;
			pos_fill[ax][id] = n + 1;
			return code;
		end
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			pos_win[ax][id][i] = pos_win[ax][id][i+1];
		end
		pos_win[ax][id][WIN_DEPTH-1] = v;
		g = longint'(pos_win[ax][id][0]) - longint'(pos_win[ax][id][1]);
		if (code != CODE_NONE)
			return (g < 0) ? CODE_DOWN_LEFT : CODE_UP_RIGHT;
		gap1 = longint'(pos_win[ax][id][WIN_DEPTH-2]) - longint'(pos_win[ax][id][WIN_DEPTH-1]);
		for (int i = WIN_DEPTH - 3; i >= 0; i--) begin
			g = longint'(pos_win[ax][id][i]) - longint'(pos_win[ax][id][i+1]);
			if ((g >= 0) == (gap1 >= 0))
				return code;
		end
		return (g < 0) ? CODE_DOWN_LEFT : CODE_UP_RIGHT;
	endfunction

	function automatic reverse_res_t predict_reversal(touch_evt_t e);
		reverse_res_t r;
		longint d;
		int id;
		r.x = e.xc;
		r.y = e.yc;
		r.np = 1'b0;
		id = int'(e.id);
		if (!det_enable) begin
			r.np = 1'b1;
		end else begin
			if (e.first) begin
				d = longint'({1'b0, e.ts}) - longint'({1'b0, last_batch_ns});
				batch_dropped = 1'b0;
				if (d >= longint'({32'd0, clear_gap}) && last_batch_ns != '0) begin
					flush_windows();
					batch_dropped = 1'b1;
				end else begin
					last_batch_ns = e.ts;
				end
			end
			if (batch_dropped) begin
				r.np = 1'b1;
			end else if (!e.finger) begin
				flush_windows();
				batch_dropped = 1'b1;
				r.np = 1'b1;
			end else if (!e.move) begin
				pos_fill[0][id] = 0;
				pos_fill[1][id] = 0;
			end else begin
				r.x = slide_axis(0, id, e.x, e.xc);
				r.y = slide_axis(1, id, e.y, e.yc);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		touch_evt_t e;
		reverse_res_t got;
		reverse_res_t want;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_idx)
					REG_ENABLE: det_enable = wr_data[0];
					REG_CLEAR_GAP: clear_gap = wr_data;
					default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				e.first  = evt.first_in_batch;
				e.ts     = evt.timestamp_ns;
				e.id     = evt.touch_id;
				e.finger = evt.is_finger;
				e.move   = evt.is_move;
				e.x      = evt.x_pos;
				e.y      = evt.y_pos;
				e.xc     = rev_code_t'(evt.x_reverse_in);
				e.yc     = rev_code_t'(evt.y_reverse_in);
				want = predict_reversal(e);
				if (pin_valid)
					want = pin_res;
				exp_store[exp_wr % EXP_DEPTH] = want;
				exp_wr++;
			end
			if (res.valid && res.ready) begin
				got.x  = rev_code_t'(res.x_reverse_out);
				got.y  = rev_code_t'(res.y_reverse_out);
				got.np = res.not_processed;
				if (exp_wr == exp_rd) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: unexpected result x %0d y %0d not_processed %0d",
							$time, got.x, got.y, got.np);
				end else begin
					want = exp_store[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							if (got.x !== want.x)
								$display("%0t: x_reverse_out expected %0d, got %0d",
									$time, want.x, got.x);
							if (got.y !== want.y)
								$display("%0t: y_reverse_out expected %0d, got %0d",
									$time, want.y, got.y);
							if (got.np !== want.np)
								$display("%0t: not_processed expected %0d, got %0d",
									$time, want.np, got.np);
						end
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_event(input touch_evt_t e, input logic pinned, input reverse_res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			evt.valid <= 1'b0;
		end
		@(negedge clk);
		evt.valid          <= 1'b1;
		evt.first_in_batch <= e.first;
		evt.timestamp_ns   <= e.ts;
		evt.touch_id       <= e.id;
		evt.is_finger      <= e.finger;
		evt.is_move        <= e.move;
		evt.x_pos          <= e.x;
		evt.y_pos          <= e.y;
		evt.x_reverse_in   <= e.xc;
		evt.y_reverse_in   <= e.yc;
		pin_valid          <= pinned;
		pin_res            <= want;
		@(posedge clk);
		while (evt.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		evt.valid <= 1'b0;
		while (exp_wr != exp_rd) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic stim_row_t ev_row(logic first, logic [TS_WIDTH-1:0] ts, int id,
			logic finger, logic move, int x, int y, rev_code_t xc, rev_code_t yc,
			logic pinned, rev_code_t wx, rev_code_t wy, logic wnp);
		stim_row_t r;
		r = '0;
		r.ev.first  = first;
		r.ev.ts     = ts;
		r.ev.id     = ID_WIDTH'(id);
		r.ev.finger = finger;
		r.ev.move   = move;
		r.ev.x      = CW'(x);
		r.ev.y      = CW'(y);
		r.ev.xc     = xc;
		r.ev.yc     = yc;
		r.pinned    = pinned;
		r.want.x    = wx;
		r.want.y    = wy;
		r.want.np   = wnp;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = val;
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		dir_rows[n_rows] = r;
		n_rows++;
	endfunction

	function automatic void step_coord(inout int pos, inout int dir, inout int run);
		int step;
		step = int'($urandom_range(1, 300));
		if (run >= 5 && $urandom_range(99) < 45) begin
			dir = -dir;
			run = 0;
		end
		pos = pos + dir * step;
		run++;
	endfunction

	task automatic slide_stroke();
		touch_evt_t e;
		reverse_res_t none_res;
		int sid;
		int px;
		int py;
		int dx;
		int dy;
		int rx;
		int ry;
		int len;
		int sel;
		none_res = '0;
		sid = ($urandom_range(3) != 0) ? int'($urandom_range(3)) : int'($urandom_range(15));
		px = int'($urandom_range(1000000)) - 500000;
		py = int'($urandom_range(1000000)) - 500000;
		dx = ($urandom_range(1) != 0) ? 1 : -1;
		dy = ($urandom_range(1) != 0) ? 1 : -1;
		rx = 0;
		ry = 0;
		len = int'($urandom_range(4, 16));
		for (int k = 0; k <= len; k++) begin
			if (k == 0 && $urandom_range(9) < 3)
				continue;
			e.first = ($urandom_range(3) == 0);
			if (e.first) begin
				sel = int'($urandom_range(99));
				if (sel < 80)
					ts_now += TS_WIDTH'($urandom_range((gap_setting > 8000) ? 4000 :
						gap_setting / 2));
				else if (sel < 92)
					ts_now += TS_WIDTH'(gap_setting) - 1 + TS_WIDTH'($urandom_range(2));
				else if (sel < 98)
					ts_now = TS_WIDTH'({$urandom, $urandom});
				else
					ts_now = ($urandom_range(1) != 0) ? '1 : '0;
				e.ts = ts_now;
			end else begin
				e.ts = TS_WIDTH'({$urandom, $urandom});
			end
			e.id = ID_WIDTH'(sid);
			if ($urandom_range(19) == 0)
				e.id = ID_WIDTH'($urandom_range(15));
			e.finger = ($urandom_range(49) != 0);
			e.move = (k != 0) && ($urandom_range(39) != 0);
			if (k > 0 && $urandom_range(9) != 0)
				step_coord(px, dx, rx);
			if (k > 0 && $urandom_range(9) != 0)
				step_coord(py, dy, ry);
			e.x = CW'(px);
			e.y = CW'(py);
			if ($urandom_range(19) == 0)
				e.x = CW'($urandom);
			if ($urandom_range(19) == 0)
				e.y = CW'($urandom);
			e.xc = ($urandom_range(9) < 7) ? CODE_NONE : rev_code_t'($urandom_range(1, 3));
			e.yc = ($urandom_range(9) < 7) ? CODE_NONE : rev_code_t'($urandom_range(1, 3));
			push_event(e, 1'b0, none_res);
			phase_items++;
		end
	endtask

	initial begin : stimulus
		logic enable_bit;
		int quota;
		bit paused;

		evt.valid          = 1'b0;
		evt.first_in_batch = 1'b0;
		evt.timestamp_ns   = '0;
		evt.touch_id       = '0;
		evt.is_finger      = 1'b0;
		evt.is_move        = 1'b0;
		evt.x_pos          = '0;
		evt.y_pos          = '0;
		evt.x_reverse_in   = '0;
		evt.y_reverse_in   = '0;
		res.ready          = 1'b0;
		wr_en              = 1'b0;
		wr_idx             = '0;
		wr_data            = '0;
		pin_valid          = 1'b0;
		pin_res            = '0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		mismatch_count     = 0;
		exp_wr             = 0;
		exp_rd             = 0;
		n_rows             = 0;
		ts_now             = '0;
		gap_setting        = CLEAR_GAP_RESET;
		phase_items        = 0;
		flush_windows();
		batch_dropped      = 1'b0;
		det_enable         = ENABLE_RESET;
		clear_gap          = CLEAR_GAP_RESET;

		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		add_row(ev_row(1, 0, 0, 1, 1, 0, 0, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(0, 0, 0, 1, 1, 524287, -524288, CODE_UP_RIGHT, CODE_DOWN_LEFT,
			1, CODE_UP_RIGHT, CODE_DOWN_LEFT, 0));
		add_row(ev_row(0, 0, 15, 1, 0, 0, 0, CODE_INITIAL, CODE_INITIAL,
			1, CODE_INITIAL, CODE_INITIAL, 0));
		for (int k = 0; k < WIN_DEPTH; k++)
			add_row(ev_row(k == 0, 1000, 1, 1, 1, 16 * k, -16 * k, CODE_NONE, CODE_NONE,
				0, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(0, 0, 1, 1, 1, 64, -64, CODE_NONE, CODE_NONE,
			0, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(0, 0, 1, 1, 1, 64, -64, CODE_UP_RIGHT, CODE_INITIAL,
			1, CODE_UP_RIGHT, CODE_INITIAL, 0));
		add_row(ev_row(0, 0, 1, 1, 1, 48, -48, CODE_INITIAL, CODE_UP_RIGHT,
			0, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(0, 0, 2, 0, 1, 7, 7, CODE_INITIAL, CODE_NONE,
			1, CODE_INITIAL, CODE_NONE, 1));
		add_row(ev_row(0, 0, 1, 1, 1, 0, 0, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 1));
		add_row(ev_row(1, 5000, 3, 1, 1, -524288, 524287, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(1, 30005000, 3, 1, 1, 1, 1, CODE_UP_RIGHT, CODE_DOWN_LEFT,
			1, CODE_UP_RIGHT, CODE_DOWN_LEFT, 1));
		add_row(ev_row(0, 0, 3, 1, 1, 2, 2, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 1));
		add_row(ev_row(1, '1, 3, 1, 1, 3, 3, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(1, 0, 3, 1, 1, 5, 5, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(cfg_row(REG_ENABLE, 0));
		add_row(ev_row(0, 0, 3, 1, 1, 9, 9, CODE_DOWN_LEFT, CODE_UP_RIGHT,
			1, CODE_DOWN_LEFT, CODE_UP_RIGHT, 1));
		add_row(cfg_row(REG_ENABLE, 1));
		add_row(cfg_row(REG_CLEAR_GAP, 0));
		add_row(ev_row(1, 100, 4, 1, 1, 0, 0, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(1, 100, 4, 1, 1, 1, 1, CODE_INITIAL, CODE_INITIAL,
			1, CODE_INITIAL, CODE_INITIAL, 1));
		add_row(cfg_row(REG_CLEAR_GAP, '1));
		add_row(ev_row(1, 63'h1_0000_0000, 4, 1, 1, 2, 2, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 0));
		add_row(ev_row(1, 63'h1_FFFF_FFFF, 4, 1, 1, 3, 3, CODE_NONE, CODE_NONE,
			1, CODE_NONE, CODE_NONE, 1));
		add_row(cfg_row(REG_CLEAR_GAP, CLEAR_GAP_RESET));

		for (int i = 0; i < n_rows; i++) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_event(dir_rows[i].ev, dir_rows[i].pinned, dir_rows[i].want);
			end
		end

		for (int phase = 0; phase < 8; phase++) begin
			settle();
			enable_bit = 1'b1;
			quota = 100;
			case (phase)
				0: gap_setting = CLEAR_GAP_RESET;
				1: gap_setting = 1000;
				2: gap_setting = '1;
				3: begin
					enable_bit = 1'b0;
					gap_setting = $urandom;
					quota = 40;
				end
				4: gap_setting = '0;
				5: gap_setting = $urandom_range(2000, 5000000);
				6: gap_setting = CLEAR_GAP_RESET;
				default: gap_setting = $urandom;
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 82;
				end
				default: begin
					send_idle_pct = 34;
					recv_stall_pct = 34;
				end
			endcase
			write_reg(REG_ENABLE, CFG_DATA_W'(enable_bit));
			write_reg(REG_CLEAR_GAP, gap_setting);
			phase_items = 0;
			paused = 1'b0;
			while (phase_items < quota) begin
				slide_stroke();
				if (!paused && phase_items >= quota / 2) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && exp_wr == exp_rd) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
